// File: rtl/flr_pkg.sv
package flr_pkg;

    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THREE_PLANES = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

    localparam logic ACTION_START   = 1'b0;
    localparam logic ACTION_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        FIG_LINE  = 2'd0,
        FIG_CROSS = 2'd1,
        FIG_RECT  = 2'd2,
        FIG_NONE  = 2'd3
    } figure_t;

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_SETUP,
        ST_DIV
    } state_t;

endpackage

// File: rtl/fixed_point_line_rasterizer_core.sv
// channel | signals                                   | beat
// in      | in_valid/in_ready, action..color_two      | start or advance item
// out     | out_valid/out_ready, pixel_x..last_pixel  | one pixel write
// cfg     | cfg_write, cfg_index, cfg_data            | register write, no wait
//
// an advance beat makes one accumulator add per pixel
// each new segment passes the setup state and then the shared restoring divider
// (DIVIDEND_W = COORD_WIDTH+2+FRACTION_BITS, 1 bit per cycle, then a done strobe);
// a zero-length segment skips the divider and goes straight back to wait
// in_ready is low during setup/divide and while an untaken pixel would be overwritten
// reset clears control state and config to defaults; no clearing pass is needed
module fixed_point_line_rasterizer_core #(
    parameter int COORD_WIDTH   = 12,
    parameter int COLOR_WIDTH   = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [1:0]                          figure,
    input  logic signed [COORD_WIDTH-1:0]       coord_a,
    input  logic signed [COORD_WIDTH-1:0]       coord_b,
    input  logic signed [COORD_WIDTH-1:0]       coord_c,
    input  logic signed [COORD_WIDTH-1:0]       coord_d,
    input  logic [COLOR_WIDTH-1:0]              color_zero,
    input  logic [COLOR_WIDTH-1:0]              color_one,
    input  logic [COLOR_WIDTH-1:0]              color_two,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_WIDTH:0]         pixel_x,
    output logic signed [COORD_WIDTH:0]         pixel_y,
    output logic [COLOR_WIDTH-1:0]              value_zero,
    output logic [COLOR_WIDTH-1:0]              value_one,
    output logic [COLOR_WIDTH-1:0]              value_two,
    output logic                                all_planes,
    output logic                                last_pixel,
    input  logic                                cfg_write,
    input  logic [flr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [flr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // endpoint, signed length, length magnitude, dividend, slope, accumulator widths
    localparam int EW = COORD_WIDTH + 2;
    localparam int LW = COORD_WIDTH + 3;
    localparam int MW = LW - 1;
    localparam int DW = MW + FRACTION_BITS;
    localparam int SW = DW + 1;
    localparam int AW = COORD_WIDTH + FRACTION_BITS + 4;
    localparam int KW = (EW > flr_pkg::CFG_DATA_W + 1) ? EW : flr_pkg::CFG_DATA_W + 1;
    localparam int PW = COORD_WIDTH + 1;

    // configuration
    logic [flr_pkg::CFG_DATA_W-1:0] image_width_reg, image_height_reg;
    logic                           three_planes_reg;

    // figure and walk state
    flr_pkg::state_t              state_reg, state_next;
    logic                         active_reg, active_next;
    flr_pkg::figure_t             kind_reg;
    logic [1:0]                   seg_reg, seg_next;
    logic signed [COORD_WIDTH-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [COLOR_WIDTH-1:0]       col0_reg, col1_reg, col2_reg;
    logic signed [EW-1:0]         major_pos_reg, major_end_reg;
    logic signed [AW-1:0]         accum_reg;
    logic signed [SW-1:0]         slope_reg;
    logic                         y_major_reg, step_down_reg, neg_reg;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic signed [PW-1:0]         px_reg, py_reg;
    logic [COLOR_WIDTH-1:0]       v0_reg, v1_reg, v2_reg;
    logic                         all_reg, last_reg;

    logic in_fire, out_free, is_start, is_adv;
    logic rect_ok, emit, walk_done, final_seg;

    // segment setup
    logic signed [EW-1:0] ea, eb, ec, ed, x1, y1, x2, y2;
    logic signed [LW-1:0] dx, dy, short_len, long_len;
    logic [MW-1:0]        adx, ady, ashort, along;
    logic signed [KW-1:0] xw_k, yh_k, wid_k, hgt_k;
    logic signed [EW-1:0] minor_start;
    logic signed [AW-1:0] accum_init;

    logic                 div_start, div_done;
    logic [DW-1:0]        div_q;
    logic signed [PW-1:0] minor_now;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == flr_pkg::ST_WAIT) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign is_start = in_fire && (action == flr_pkg::ACTION_START);
    assign is_adv   = in_fire && (action == flr_pkg::ACTION_ADVANCE);

    // rectangle origin must be non-negative and origin plus size below width and height
    always_comb
    begin
        xw_k    = KW'(EW'(coord_a) + EW'(coord_c));
        yh_k    = KW'(EW'(coord_b) + EW'(coord_d));
        wid_k   = KW'({1'b0, image_width_reg});
        hgt_k   = KW'({1'b0, image_height_reg});
        rect_ok = !coord_a[COORD_WIDTH-1] && !coord_b[COORD_WIDTH-1]
                  && (xw_k < wid_k) && (yh_k < hgt_k);
    end

    // endpoints of the current segment
    always_comb
    begin
        ea = EW'(pa_reg);
        eb = EW'(pb_reg);
        ec = EW'(pc_reg);
        ed = EW'(pd_reg);
        x1 = ea;
        y1 = eb;
        x2 = ec;
        y2 = ed;
        unique case (kind_reg)
            flr_pkg::FIG_CROSS:
            begin
                if (seg_reg == 2'd0)
                begin
                    x1 = ea - ec;
                    y1 = eb;
                    x2 = ea + ec;
                    y2 = eb;
                end
                else
                begin
                    x1 = ea;
                    y1 = eb - ec;
                    x2 = ea;
                    y2 = eb + ec;
                end
            end
            flr_pkg::FIG_RECT:
            begin
                unique case (seg_reg)
                    2'd0:
                    begin
                        x1 = ea;      y1 = eb;      x2 = ea + ec; y2 = eb;
                    end
                    2'd1:
                    begin
                        x1 = ea + ec; y1 = eb;      x2 = ea + ec; y2 = eb + ed;
                    end
                    2'd2:
                    begin
                        x1 = ea + ec; y1 = eb + ed; x2 = ea;      y2 = eb + ed;
                    end
                    default:
                    begin
                        x1 = ea;      y1 = eb + ed; x2 = ea;      y2 = eb;
                    end
                endcase
            end
            default:
            begin
                x1 = ea;
                y1 = eb;
                x2 = ec;
                y2 = ed;
            end
        endcase
    end

    // lengths, axis choice and accumulator start
    always_comb
    begin
        dx  = LW'(x2) - LW'(x1);
        dy  = LW'(y2) - LW'(y1);
        adx = MW'(dx[LW-1] ? -dx : dx);
        ady = MW'(dy[LW-1] ? -dy : dy);
        if (ady > adx)
        begin
            short_len   = dx;
            long_len    = dy;
            ashort      = adx;
            along       = ady;
            minor_start = x1;
        end
        else
        begin
            short_len   = dy;
            long_len    = dx;
            ashort      = ady;
            along       = adx;
            minor_start = y1;
        end
        accum_init = (AW'(minor_start) <<< FRACTION_BITS)
                     | (AW'(1) << (FRACTION_BITS - 1));
    end

    assign div_start = (state_reg == flr_pkg::ST_SETUP) && (along != '0);

    flr_divider #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({ashort, FRACTION_BITS'(0)}),
        .divisor  (along),
        .done     (div_done),
        .quotient (div_q)
    );

    // walk decisions
    assign emit      = is_adv && active_reg;
    assign walk_done = (major_pos_reg == major_end_reg);
    always_comb
    begin
        unique case (kind_reg)
            flr_pkg::FIG_LINE:  final_seg = (seg_reg == 2'd0);
            flr_pkg::FIG_CROSS: final_seg = (seg_reg == 2'd1);
            default:            final_seg = (seg_reg == 2'd3);
        endcase
    end

    // floor shift of the accumulator
    assign minor_now = PW'(accum_reg >>> FRACTION_BITS);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            flr_pkg::ST_WAIT:
            begin
                if (is_start)
                begin
                    seg_next = 2'd0;
                    if (figure == flr_pkg::FIG_NONE
                        || (figure == flr_pkg::FIG_RECT && !rect_ok))
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        state_next  = flr_pkg::ST_SETUP;
                    end
                end
                else if (emit)
                begin
                    out_valid_next = 1'b1;
                    if (walk_done)
                    begin
                        if (final_seg)
                        begin
                            active_next = 1'b0;
                            seg_next    = 2'd0;
                        end
                        else
                        begin
                            seg_next   = seg_reg + 2'd1;
                            state_next = flr_pkg::ST_SETUP;
                        end
                    end
                end
            end
            flr_pkg::ST_SETUP:
            begin
                state_next = (along != '0) ? flr_pkg::ST_DIV : flr_pkg::ST_WAIT;
            end
            flr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = flr_pkg::ST_WAIT;
                end
            end
            default:
            begin
                state_next = flr_pkg::ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= flr_pkg::ST_WAIT;
            active_reg       <= 1'b0;
            seg_reg          <= 2'd0;
            out_valid_reg    <= 1'b0;
            image_width_reg  <= flr_pkg::RESET_IMAGE_WIDTH;
            image_height_reg <= flr_pkg::RESET_IMAGE_HEIGHT;
            three_planes_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    flr_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    flr_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    flr_pkg::REG_THREE_PLANES: three_planes_reg <= cfg_data[0];
                    default:                   ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (is_start)
        begin
            kind_reg <= flr_pkg::figure_t'(figure);
            pa_reg   <= coord_a;
            pb_reg   <= coord_b;
            pc_reg   <= coord_c;
            pd_reg   <= coord_d;
            col0_reg <= color_zero;
            col1_reg <= color_one;
            col2_reg <= color_two;
        end
        if (state_reg == flr_pkg::ST_SETUP)
        begin
            y_major_reg   <= (ady > adx);
            step_down_reg <= !(long_len > 0);
            neg_reg       <= short_len[LW-1] ^ long_len[LW-1];
            major_pos_reg <= (ady > adx) ? y1 : x1;
            major_end_reg <= (ady > adx) ? y2 : x2;
            accum_reg     <= accum_init;
            slope_reg     <= '0;
        end
        if (div_done)
        begin
            slope_reg <= neg_reg ? -SW'(div_q) : SW'(div_q);
        end
        if (emit && !walk_done)
        begin
            if (step_down_reg)
            begin
                major_pos_reg <= major_pos_reg - EW'(1);
                accum_reg     <= accum_reg - AW'(slope_reg);
            end
            else
            begin
                major_pos_reg <= major_pos_reg + EW'(1);
                accum_reg     <= accum_reg + AW'(slope_reg);
            end
        end
        if (emit)
        begin
            px_reg   <= y_major_reg ? minor_now : PW'(major_pos_reg);
            py_reg   <= y_major_reg ? PW'(major_pos_reg) : minor_now;
            v0_reg   <= col0_reg;
            v1_reg   <= three_planes_reg ? col1_reg : '0;
            v2_reg   <= three_planes_reg ? col2_reg : '0;
            all_reg  <= three_planes_reg;
            last_reg <= walk_done && final_seg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign value_zero = v0_reg;
    assign value_one  = v1_reg;
    assign value_two  = v2_reg;
    assign all_planes = all_reg;
    assign last_pixel = last_reg;

endmodule

// File: rtl/flr_divider.sv
module flr_divider #(
    parameter int DIVIDEND_W = 30,
    parameter int DIVISOR_W  = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  fit;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        shifted   = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
        fit       = (shifted >= {1'b0, div_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fit ? (shifted - {1'b0, div_reg}) : shifted;
            quo_next = {quo_reg[DIVIDEND_W-2:0], fit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/flr_checker.sv
module flr_port_props (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic action,
    input logic out_valid,
    input logic out_ready,
    input logic [12:0] pixel_x,
    input logic [12:0] pixel_y,
    input logic last_pixel
);

    // a waiting pixel is held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x)
            && $stable(pixel_y) && $stable(last_pixel))
        else $error("pending pixel changed");

    // no new beat while a pixel would be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken over a pending pixel");

    // a start beat never produces a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == flr_pkg::ACTION_START) && !out_valid
            |=> !out_valid)
        else $error("pixel after start beat");

endmodule

bind fixed_point_line_rasterizer_core flr_port_props u_flr_port_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
);

// File: sim/flr_checker.sv
module flr_checker
    import flr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               action,
    input  logic [1:0]         figure,
    input  logic signed [11:0] coord_a,
    input  logic signed [11:0] coord_b,
    input  logic signed [11:0] coord_c,
    input  logic signed [11:0] coord_d,
    input  logic [7:0]         color_zero,
    input  logic [7:0]         color_one,
    input  logic [7:0]         color_two,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [12:0] pixel_x,
    input  logic signed [12:0] pixel_y,
    input  logic [7:0]         value_zero,
    input  logic [7:0]         value_one,
    input  logic [7:0]         value_two,
    input  logic               all_planes,
    input  logic               last_pixel,
    input  logic               cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                 mismatches,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
        logic [7:0]  v0;
        logic [7:0]  v1;
        logic [7:0]  v2;
        logic        planes;
        logic        last;
    } pixel_t;

    pixel_t pixel_queue[$];

    // register copies
    int   img_w;
    int   img_h;
    logic planes;

    // walker state
    logic    walking;
    figure_t shape;
    int      seg;
    int      par[4];
    logic [7:0] col[3];
    int      pos;
    int      stop;
    longint  acc;
    longint  inc;
    logic    steep;
    logic    backward;

    assign pending = pixel_queue.size();

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void aim_line(int x1, int y1, int x2, int y2);
        int sl;
        int ll;
        int t;
        sl = y2 - y1;
        ll = x2 - x1;
        steep = 1'b0;
        if (mag(sl) > mag(ll))
        begin
            t = sl;
            sl = ll;
            ll = t;
            steep = 1'b1;
        end
        inc = (ll == 0) ? 64'sd0 : (longint'(sl) * 65536) / longint'(ll);
        backward = !(ll > 0);
        if (steep)
        begin
            pos = y1;
            stop = y1 + ll;
            acc = 32768 + longint'(x1) * 65536;
        end
        else
        begin
            pos = x1;
            stop = x1 + ll;
            acc = 32768 + longint'(y1) * 65536;
        end
    endfunction

    function automatic void aim_segment();
        int a;
        int b;
        int c;
        int d;
        a = par[0];
        b = par[1];
        c = par[2];
        d = par[3];
        if (shape == FIG_LINE)
            aim_line(a, b, c, d);
        else if (shape == FIG_CROSS)
        begin
            if (seg == 0)
                aim_line(a - c, b, a + c, b);
            else
                aim_line(a, b - c, a, b + c);
        end
        else
        begin
            case (seg)
                0: aim_line(a, b, a + c, b);
                1: aim_line(a + c, b, a + c, b + d);
                2: aim_line(a + c, b + d, a, b + d);
                default: aim_line(a, b + d, a, b);
            endcase
        end
    endfunction

    // returns 1 and the pixel when the beat draws one
    function automatic logic rasterize(output pixel_t px);
        int   minor;
        int   nseg;
        logic done;
        px = '0;
        if (action == ACTION_START)
        begin
            shape = figure_t'(figure);
            par[0] = coord_a;
            par[1] = coord_b;
            par[2] = coord_c;
            par[3] = coord_d;
            col[0] = color_zero;
            col[1] = color_one;
            col[2] = color_two;
            seg = 0;
            walking = 1'b0;
            if (shape == FIG_NONE)
                return 1'b0;
            // rectangle origin must be non-negative and origin plus size below width and height
            if (shape == FIG_RECT && !(par[0] >= 0 && par[1] >= 0 &&
                par[0] + par[2] < img_w && par[1] + par[3] < img_h))
                return 1'b0;
            walking = 1'b1;
            aim_segment();
            return 1'b0;
        end
        if (!walking)
            return 1'b0;
        minor = int'(acc >>> 16);
        px.x = steep ? minor[12:0] : pos[12:0];
        px.y = steep ? pos[12:0] : minor[12:0];
        px.v0 = col[0];
        px.v1 = planes ? col[1] : 8'd0;
        px.v2 = planes ? col[2] : 8'd0;
        px.planes = planes;
        done = (pos == stop);
        nseg = (shape == FIG_LINE) ? 1 : (shape == FIG_CROSS) ? 2 : 4;
        if (done)
        begin
            seg++;
            if (seg >= nseg)
            begin
                walking = 1'b0;
                seg = 0;
                px.last = 1'b1;
            end
            else
                aim_segment();
        end
        else if (backward)
        begin
            pos--;
            acc -= inc;
        end
        else
        begin
            pos++;
            acc += inc;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            img_w = RESET_IMAGE_WIDTH;
            img_h = RESET_IMAGE_HEIGHT;
            planes = 1'b0;
            walking = 1'b0;
            shape = FIG_LINE;
            seg = 0;
            pixel_queue.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {pixel_x, pixel_y, value_zero, value_one, value_two,
                       all_planes, last_pixel};
                if (pixel_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: exp x=%0d y=%0d v=%h/%h/%h p=%b l=%b, got x=%0d y=%0d v=%h/%h/%h p=%b l=%b",
                                $signed(want.x), $signed(want.y), want.v0, want.v1,
                                want.v2, want.planes, want.last,
                                pixel_x, pixel_y, value_zero, value_one, value_two,
                                all_planes, last_pixel);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (rasterize(want))
                    pixel_queue.push_back(want);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  img_w = cfg_data;
                    REG_IMAGE_HEIGHT: img_h = cfg_data;
                    REG_THREE_PLANES: planes = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import flr_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               action = ACTION_ADVANCE;
    logic [1:0]         figure = FIG_LINE;
    logic signed [11:0] coord_a = '0;
    logic signed [11:0] coord_b = '0;
    logic signed [11:0] coord_c = '0;
    logic signed [11:0] coord_d = '0;
    logic [7:0]         color_zero = '0;
    logic [7:0]         color_one = '0;
    logic [7:0]         color_two = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [12:0] pixel_x;
    logic signed [12:0] pixel_y;
    logic [7:0]         value_zero;
    logic [7:0]         value_one;
    logic [7:0]         value_two;
    logic               all_planes;
    logic               last_pixel;
    logic               cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int pending;

    // sender burst shaping
    int burst_left = 0;
    int gapless = 0;
    // width and height currently programmed, used to aim rectangles inside
    int tb_w = 640;
    int tb_h = 480;
    int sent = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fixed_point_line_rasterizer_core dut (.*);

    flr_checker checker_i (.*);

    // receiver stall pattern: rx_mode is redrawn at random between always ready, random ready and long stalls
    int stall_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 200 == 0)
            rx_mode = $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (rx_mode == 0)
            out_ready <= 1'b1;
        else if (rx_mode == 1)
            out_ready <= 1'($urandom_range(0, 1));
        else if ($urandom_range(0, 7) == 0)
        begin
            // long stall
            stall_left = $urandom_range(1, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic int fit(int v);
        return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
    endfunction

    // one beat on the input channel; valid stays up into the next beat
    task automatic send_beat(logic act, logic [1:0] fig, int a, int b, int c, int d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (gapless > 0)
                gapless--;
            else if ($urandom_range(0, 9) == 0)
                gapless = $urandom_range(3, 10);
            gap = (gapless > 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        figure <= fig;
        coord_a <= 12'(a);
        coord_b <= 12'(b);
        coord_c <= 12'(c);
        coord_d <= 12'(d);
        color_zero <= 8'($urandom);
        color_one <= 8'($urandom);
        color_two <= 8'($urandom);
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic advance(int n);
        repeat (n) send_beat(ACTION_ADVANCE, FIG_LINE, $urandom, $urandom,
                             $urandom, $urandom);
    endtask

    // register writes only once the block is idle
    task automatic configure(int w, int h, logic three);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // a start beat may still be dividing
        repeat (50) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= 12'(w);
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= 12'(h);
        @(negedge clk);
        cfg_index <= REG_THREE_PLANES;
        cfg_data <= 12'(three);
        @(negedge clk);
        cfg_write <= 1'b0;
        tb_w = w;
        tb_h = h;
    endtask

    // random figure start followed by a random run of advances
    task automatic random_figure();
        int k;
        int x;
        int y;
        k = $urandom_range(0, 99);
        x = $signed(12'($urandom));
        y = $signed(12'($urandom));
        if (k < 8)
            // raw fields, every bit and code reachable
            send_beat(ACTION_START, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
        else if (k < 50)
            send_beat(ACTION_START, FIG_LINE, x, y,
                      fit(x + $signed($urandom_range(0, 60)) - 30),
                      fit(y + $signed($urandom_range(0, 60)) - 30));
        else if (k < 68)
            send_beat(ACTION_START, FIG_CROSS, x, y,
                      $signed($urandom_range(0, 22)) - 2, $urandom);
        else if (k < 95)
        begin
            // mostly inside the image, sometimes just past an edge
            x = $urandom_range(0, (tb_w > 30) ? 30 : tb_w - 1);
            y = $urandom_range(0, (tb_h > 30) ? 30 : tb_h - 1);
            send_beat(ACTION_START, FIG_RECT, x, y,
                      $signed($urandom_range(0, 20)) - 3,
                      $signed($urandom_range(0, 20)) - 3);
        end
        else
            send_beat(ACTION_START, FIG_NONE, x, y, 0, 0);
        advance($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(10, 90));
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        configure(640, 480, 1'b1);

        // directed: idle advance, shallow and steep lines, zero length,
        // extremes, cross, rectangle in and out, the none code, abandon
        advance(1);
        send_beat(ACTION_START, FIG_LINE, 0, 0, 5, 2);
        advance(7);
        send_beat(ACTION_START, FIG_LINE, -2048, 2047, -2048, 2047);
        advance(2);
        send_beat(ACTION_START, FIG_LINE, 10, 10, 7, -3);
        advance(4);
        send_beat(ACTION_START, FIG_CROSS, 2047, -2048, 1, 0);
        advance(6);
        send_beat(ACTION_START, FIG_RECT, 1, 1, 1, 1);
        advance(9);
        send_beat(ACTION_START, FIG_RECT, -1, 0, 2, 2);
        advance(1);
        send_beat(ACTION_START, FIG_NONE, 0, 0, 0, 0);
        advance(1);

        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: configure(1, 1, 1'b0);
                2: configure(4095, 4095, 1'b1);
                3: configure(25, 12, 1'b0);
                4: configure($urandom_range(1, 4095), $urandom_range(1, 4095), 1'b1);
                default: ;
            endcase
            while (sent < (phase + 1) * 150)
                random_figure();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hang guard
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
